// ===== design/egas_pkg.sv =====
// Shared widths, word types, stage types and helper functions of the action selector.
package egas_pkg;

    localparam int ACTION_COUNT = 4;
    localparam int VALUE_WIDTH  = 16;
    localparam int DRAW_WIDTH   = 16;
    localparam int EPS_WIDTH    = 17;
    localparam int ACT_WIDTH    = 2;
    localparam int CNT_WIDTH    = 3;
    localparam int DSUM_WIDTH   = 5;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 17'd6554;

    localparam logic [CNT_WIDTH-1:0] CNT_ONE   = 3'd1;
    localparam logic [CNT_WIDTH-1:0] CNT_TWO   = 3'd2;
    localparam logic [CNT_WIDTH-1:0] CNT_THREE = 3'd3;
    localparam logic [CNT_WIDTH-1:0] CNT_FOUR  = 3'd4;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] q_value_0;
        logic signed [VALUE_WIDTH-1:0] q_value_1;
        logic signed [VALUE_WIDTH-1:0] q_value_2;
        logic signed [VALUE_WIDTH-1:0] q_value_3;
        logic [ACTION_COUNT-1:0]       available_mask;
        logic [DRAW_WIDTH-1:0]         explore_draw;
        logic [DRAW_WIDTH-1:0]         pick_draw;
    } t_in_word;

    typedef struct packed {
        logic [ACT_WIDTH-1:0] chosen_action;
        logic                 explored;
        logic                 no_action;
    } t_out_word;

    // first stage: values kept for the tie test, pairwise maxima, draw residue parts
    typedef struct packed {
        logic [ACTION_COUNT-1:0][VALUE_WIDTH-1:0] q;
        logic [ACTION_COUNT-1:0]                  mask;
        logic                                     explore;
        logic                                     none;
        logic [1:0][VALUE_WIDTH-1:0]              pair_max;
        logic [1:0]                               pair_ok;
        logic [1:0]                               pick_lo;
        logic [DSUM_WIDTH-1:0]                    dsum;
    } t_s1;

    // second stage: candidate set and index into it
    typedef struct packed {
        logic [ACTION_COUNT-1:0] cand;
        logic [ACT_WIDTH-1:0]    residue;
        logic                    explored;
        logic                    none;
    } t_s2;

    function automatic logic [CNT_WIDTH-1:0] bit_count(input logic [ACTION_COUNT-1:0] set);
        logic [CNT_WIDTH-1:0] c;
        c = '0;
        for (int i = 0; i < ACTION_COUNT; i++) begin
            c = c + CNT_WIDTH'(set[i]);
        end
        return c;
    endfunction

    // index of the n-th set bit, counting upward; zero for an empty set
    function automatic logic [ACT_WIDTH-1:0] nth_set(input logic [ACTION_COUNT-1:0] set,
                                                     input logic [ACT_WIDTH-1:0] n);
        logic [ACT_WIDTH-1:0] idx;
        logic [CNT_WIDTH-1:0] seen;
        idx  = '0;
        seen = '0;
        for (int i = 0; i < ACTION_COUNT; i++) begin
            if (set[i]) begin
                if (seen == CNT_WIDTH'(n)) begin
                    idx = ACT_WIDTH'(i);
                end
                seen = seen + CNT_WIDTH'(1);
            end
        end
        return idx;
    endfunction

    // 4 = 1 mod 3, so the base-4 digit sum keeps the residue mod 3
    function automatic logic [DSUM_WIDTH-1:0] digit_sum(input logic [DRAW_WIDTH-1:0] d);
        logic [DSUM_WIDTH-1:0] s;
        s = '0;
        for (int i = 0; i < DRAW_WIDTH / 2; i++) begin
            s = s + DSUM_WIDTH'(d[2*i +: 2]);
        end
        return s;
    endfunction

    function automatic logic [1:0] fold_mod3(input logic [DSUM_WIDTH-1:0] s);
        logic [2:0] t;
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

// ===== design/egas_front.sv =====
// First stage: explore decision, pairwise maxima over allowed values, draw digit sum.
module egas_front import egas_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_in_word             i_word,
    input  logic [EPS_WIDTH-1:0] i_epsilon,
    output t_s1                  o_s1
);

    t_s1 r_s1;
    t_s1 n_s1;

    always_comb begin
        logic signed [VALUE_WIDTH-1:0] a;
        logic signed [VALUE_WIDTH-1:0] b;
        n_s1      = '0;
        n_s1.q[0] = i_word.q_value_0;
        n_s1.q[1] = i_word.q_value_1;
        n_s1.q[2] = i_word.q_value_2;
        n_s1.q[3] = i_word.q_value_3;
        n_s1.mask = i_word.available_mask;
        n_s1.none = (i_word.available_mask == '0);
        n_s1.explore = !n_s1.none &&
                       ({1'b0, i_word.explore_draw} < i_epsilon);
        for (int p = 0; p < 2; p++) begin
            a = $signed(n_s1.q[2*p]);
            b = $signed(n_s1.q[2*p+1]);
            n_s1.pair_ok[p] = n_s1.mask[2*p] | n_s1.mask[2*p+1];
            if (n_s1.mask[2*p] && n_s1.mask[2*p+1]) begin
                n_s1.pair_max[p] = (b > a) ? b : a;
            end else if (n_s1.mask[2*p+1]) begin
                n_s1.pair_max[p] = b;
            end else begin
                n_s1.pair_max[p] = a;
            end
        end
        n_s1.pick_lo = i_word.pick_draw[1:0];
        n_s1.dsum    = digit_sum(i_word.pick_draw);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// ===== design/egas_resolve.sv =====
// Second stage: overall maximum, tie set, candidate set and its pick index.
module egas_resolve import egas_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_s1  i_s1,
    output t_s2  o_s2
);

    t_s2 r_s2;
    t_s2 n_s2;

    always_comb begin
        logic signed [VALUE_WIDTH-1:0] best;
        logic signed [VALUE_WIDTH-1:0] lo;
        logic signed [VALUE_WIDTH-1:0] hi;
        logic [ACTION_COUNT-1:0]       ties;
        logic [CNT_WIDTH-1:0]          count;
        lo = $signed(i_s1.pair_max[0]);
        hi = $signed(i_s1.pair_max[1]);
        if (i_s1.pair_ok[0] && i_s1.pair_ok[1]) begin
            best = (hi > lo) ? hi : lo;
        end else if (i_s1.pair_ok[1]) begin
            best = hi;
        end else begin
            best = lo;
        end
        for (int i = 0; i < ACTION_COUNT; i++) begin
            ties[i] = i_s1.mask[i] && ($signed(i_s1.q[i]) == best);
        end
        n_s2          = '0;
        n_s2.cand     = i_s1.explore ? i_s1.mask : ties;
        n_s2.explored = i_s1.explore;
        n_s2.none     = i_s1.none;
        count         = bit_count(n_s2.cand);
        // pick draw modulo the candidate count
        unique case (count)
            CNT_ONE:   n_s2.residue = '0;
            CNT_TWO:   n_s2.residue = {1'b0, i_s1.pick_lo[0]};
            CNT_THREE: n_s2.residue = fold_mod3(i_s1.dsum);
            CNT_FOUR:  n_s2.residue = i_s1.pick_lo;
            default:   n_s2.residue = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

// ===== design/egas_pick.sv =====
// Third stage: n-th candidate lookup into the output word register.
module egas_pick import egas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_s2       i_s2,
    output t_out_word o_word
);

    t_out_word r_word;
    t_out_word n_word;

    always_comb begin
        n_word.chosen_action = nth_set(i_s2.cand, i_s2.residue);
        n_word.explored      = i_s2.explored;
        n_word.no_action     = i_s2.none;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== design/epsilon_greedy_action_select_unit.sv =====
// Top level of the epsilon-greedy action selector: stage control and epsilon register.
//
//  channel  | signals                          | direction | word
//  ---------+----------------------------------+-----------+-----------
//  input    | i_in_valid, o_in_ready, i_in_word | in        | t_in_word
//  result   | o_out_valid, i_out_ready, o_out_word | out    | t_out_word
//  config   | i_cfg_we, i_cfg_wdata            | in        | epsilon
//
// One word per cycle sustained while the output is not stalled; the acceptance
// edge loads the front stage, and the word then passes through the resolve
// stage register into the output register (pick stage) before it is handed off.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and a stalled output holds its word without loss.
// Synchronous active-low reset empties all stages and sets epsilon to 6554.
module epsilon_greedy_action_select_unit import egas_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_we,
    input  logic [EPS_WIDTH-1:0] i_cfg_wdata
);

    logic [EPS_WIDTH-1:0] r_epsilon;
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;

    logic en1;
    logic en2;
    logic en3;
    t_s1  s1;
    t_s2  s2;

    // advance chain from the output back to the input
    assign en3 = !r_v3 || i_out_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_ready  = en1;
    assign o_out_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_epsilon <= i_cfg_wdata;
        end
    end

    // valid bits follow their words through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    egas_front u_front (
        .i_clk     (i_clk),
        .i_en      (en1),
        .i_word    (i_in_word),
        .i_epsilon (r_epsilon),
        .o_s1      (s1)
    );

    egas_resolve u_resolve (
        .i_clk (i_clk),
        .i_en  (en2),
        .i_s1  (s1),
        .o_s2  (s2)
    );

    egas_pick u_pick (
        .i_clk  (i_clk),
        .i_en   (en3),
        .i_s2   (s2),
        .o_word (o_out_word)
    );

endmodule
